// ===== design/mlt_pkg.sv =====
package mlt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RETRY_MAX_SECONDS = 30;
  localparam int GRACE_SECONDS = 10;
  localparam int BACKOFF_CAP_RETRIES = 6;
  localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;
  localparam logic [63:0] GRACE_NS = 64'(GRACE_SECONDS) * 64'(NS_PER_SECOND);

  localparam logic [1:0] CMD_LEARN    = 2'd0;
  localparam logic [1:0] CMD_AGE      = 2'd1;
  localparam logic [1:0] CMD_FLUSH_PT = 2'd2;
  localparam logic [1:0] CMD_FLUSH_SW = 2'd3;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_INVALID = 2'd1;
  localparam logic [1:0] STS_FULL    = 2'd2;
  localparam logic [1:0] STS_QFAIL   = 2'd3;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_ADDED     = 3'd1;
  localparam logic [2:0] EV_REFRESHED = 3'd2;
  localparam logic [2:0] EV_MOVED     = 3'd3;
  localparam logic [2:0] EV_REMOVED   = 3'd4;
  localparam logic [2:0] EV_RETRY     = 3'd5;
  localparam logic [2:0] EV_ACTIVITY  = 3'd6;

  localparam logic CFG_AGING    = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_AGE_RD,
    S_AGE_CALC,
    S_AGE_EVAL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [15:0] switch_id;
    logic [11:0] vlan;
    logic [47:0] mac;
    logic [15:0] port;
    logic [63:0] last_seen;
    logic [63:0] last_packets;
    logic        in_retry;
    logic [31:0] retry_cnt;
    logic [63:0] next_retry;
  } entry_t;

  typedef struct packed {
    logic        we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
  } store_ctl_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] event_res;
    logic [6:0] removed_count;
    logic [5:0] entry_slot;
  } result_t;

  function automatic logic [63:0] cap_sec(input int s);
    return (s > RETRY_MAX_SECONDS) ? 64'(RETRY_MAX_SECONDS) : 64'(s);
  endfunction

  // backoff in ns for a retry count, constants per arm
  function automatic logic [63:0] backoff_ns(input logic [31:0] retries);
    logic [63:0] r;
    r = '0;
    if (retries == 32'd0) begin
      r = '0;
    end else if (retries >= 32'(BACKOFF_CAP_RETRIES)) begin
      r = cap_sec(RETRY_MAX_SECONDS) * 64'(NS_PER_SECOND);
    end else begin
      case (retries[2:0])
        3'd1:    r = cap_sec(1) * 64'(NS_PER_SECOND);
        3'd2:    r = cap_sec(2) * 64'(NS_PER_SECOND);
        3'd3:    r = cap_sec(4) * 64'(NS_PER_SECOND);
        3'd4:    r = cap_sec(8) * 64'(NS_PER_SECOND);
        3'd5:    r = cap_sec(16) * 64'(NS_PER_SECOND);
        default: r = cap_sec(RETRY_MAX_SECONDS) * 64'(NS_PER_SECOND);
      endcase
    end
    return r;
  endfunction

endpackage

// ===== design/mlt_store.sv =====
module mlt_store (
  input  logic                  clk,
  input  mlt_pkg::store_ctl_t   ctl,
  input  mlt_pkg::entry_t       wdata,
  output mlt_pkg::entry_t       rdata_r
);

  mlt_pkg::entry_t mem [mlt_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
    rdata_r <= mem[ctl.raddr];
  end

endmodule

// ===== design/mac_learning_table_aging.sv =====
// learn and flush scan all 64 slots, one per cycle through the entry memory
// read port; a learn hit ends the scan at the matching slot
// age of one slot: read, multiply, evaluate, then output; an empty slot goes from
// the read straight to output; rejected or ignored items go straight to output
// one transaction at a time; in_stall is high until the result is registered;
// reset: synchronous, active low, clears valid bits and count
module mac_learning_table_aging (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_switch_id,
  input  logic [11:0] in_vlan,
  input  logic [47:0] in_mac,
  input  logic [15:0] in_port,
  input  logic [63:0] in_now_ns,
  input  logic [5:0]  in_slot,
  input  logic [63:0] in_packet_count,
  input  logic        in_query_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_event_res,
  output logic [6:0]  out_removed_count,
  output logic [5:0]  out_entry_slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = mlt_pkg::ADDR_W;
  localparam int CW = mlt_pkg::CNT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(mlt_pkg::TABLE_DEPTH - 1);
  localparam logic [61:0] NS62 = 62'(mlt_pkg::NS_PER_SECOND);

  mlt_pkg::state_t state_r, state_nxt;

  logic [1:0]  cmd_r;
  logic [15:0] sw_r;
  logic [11:0] vl_r;
  logic [47:0] mac_r;
  logic [15:0] port_r;
  logic [63:0] now_r;
  logic [5:0]  slot_r;
  logic [63:0] pk_r;
  logic        ok_r;

  logic [31:0] aging_r, aging_nxt;
  logic [6:0]  cap_r, cap_nxt;
  logic [mlt_pkg::TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [6:0]  total_r, total_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        chk_vld_r, chk_vld_nxt;
  logic [AW-1:0] chk_idx_r, chk_idx_nxt;
  logic        fr_found_r, fr_found_nxt;
  logic [AW-1:0] fr_r, fr_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [63:0] idle_r, idle_nxt;
  logic [61:0] aging_ns_r, aging_ns_nxt;
  logic [31:0] retries_r, retries_nxt;
  mlt_pkg::result_t res_r, res_nxt;
  mlt_pkg::result_t out_res_r, out_res_nxt;
  logic        out_valid_r, out_valid_nxt;

  mlt_pkg::store_ctl_t ctl;
  mlt_pkg::entry_t     wdata;
  mlt_pkg::entry_t     rd;

  logic in_acc;
  logic hit;
  logic flush_hit;
  logic free_any;
  logic [AW-1:0] free_sel;
  logic [6:0] rem_new;
  logic [63:0] aging_ns64;

  mlt_store u_store (
    .clk     (clk),
    .ctl     (ctl),
    .wdata   (wdata),
    .rdata_r (rd)
  );

  assign in_acc     = in_valid && !in_stall;
  assign in_stall   = (state_r != mlt_pkg::S_IDLE);
  assign cfg_ready  = (state_r == mlt_pkg::S_IDLE);
  assign aging_ns64 = 64'(aging_ns_r);

  assign hit = valid_r[chk_idx_r] && (rd.switch_id == sw_r) && (rd.vlan == vl_r) &&
               (rd.mac == mac_r);
  assign flush_hit = valid_r[chk_idx_r] && (rd.switch_id == sw_r) &&
                     ((cmd_r == mlt_pkg::CMD_FLUSH_SW) || (rd.port == port_r));
  assign free_any = fr_found_r || !valid_r[chk_idx_r];
  assign free_sel = fr_found_r ? fr_r : chk_idx_r;
  assign rem_new  = rem_r + 7'(flush_hit);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_command;
      sw_r   <= in_switch_id;
      vl_r   <= in_vlan;
      mac_r  <= in_mac;
      port_r <= in_port;
      now_r  <= in_now_ns;
      slot_r <= in_slot;
      pk_r   <= in_packet_count;
      ok_r   <= in_query_ok;
    end
    chk_idx_r  <= chk_idx_nxt;
    fr_r       <= fr_nxt;
    idle_r     <= idle_nxt;
    aging_ns_r <= aging_ns_nxt;
    retries_r  <= retries_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlt_pkg::S_IDLE;
      aging_r     <= 32'd300;
      cap_r       <= 7'd64;
      valid_r     <= '0;
      total_r     <= '0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      fr_found_r  <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      aging_r     <= aging_nxt;
      cap_r       <= cap_nxt;
      valid_r     <= valid_nxt;
      total_r     <= total_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      fr_found_r  <= fr_found_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    aging_nxt     = aging_r;
    cap_nxt       = cap_r;
    valid_nxt     = valid_r;
    total_nxt     = total_r;
    cnt_nxt       = cnt_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    fr_found_nxt  = fr_found_r;
    fr_nxt        = fr_r;
    rem_nxt       = rem_r;
    idle_nxt      = idle_r;
    aging_ns_nxt  = aging_ns_r;
    retries_nxt   = retries_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl.we        = 1'b0;
    ctl.waddr     = chk_idx_r;
    ctl.raddr     = cnt_r[AW-1:0];
    wdata         = rd;

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == mlt_pkg::CFG_AGING) begin
        aging_nxt = cfg_data;
      end else begin
        cap_nxt = cfg_data[6:0];
      end
    end

    case (state_r)
      mlt_pkg::S_IDLE: begin
        cnt_nxt      = '0;
        chk_vld_nxt  = 1'b0;
        fr_found_nxt = 1'b0;
        rem_nxt      = '0;
        if (in_acc) begin
          res_nxt = '{mlt_pkg::STS_OK, mlt_pkg::EV_NONE, 7'd0, 6'd0};
          if (in_command == mlt_pkg::CMD_AGE) begin
            state_nxt = mlt_pkg::S_AGE_RD;
          end else if (in_switch_id == 16'd0) begin
            res_nxt.status = mlt_pkg::STS_INVALID;
            state_nxt      = mlt_pkg::S_OUT;
          end else if ((in_command == mlt_pkg::CMD_LEARN) &&
                       ((in_mac == 48'd0) || in_mac[40])) begin
            // multicast or zero source is ignored
            state_nxt = mlt_pkg::S_OUT;
          end else begin
            state_nxt = mlt_pkg::S_SCAN;
          end
        end
      end

      mlt_pkg::S_SCAN: begin
        // read issue runs one slot ahead of the compare
        if (cnt_r < CW'(mlt_pkg::TABLE_DEPTH)) begin
          cnt_nxt     = cnt_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = cnt_r[AW-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          if (cmd_r == mlt_pkg::CMD_LEARN) begin
            if (hit) begin
              ctl.we          = 1'b1;
              ctl.waddr       = chk_idx_r;
              wdata.last_seen = now_r;
              res_nxt = '{mlt_pkg::STS_OK, mlt_pkg::EV_REFRESHED, 7'd0, 6'(chk_idx_r)};
              if (rd.port != port_r) begin
                wdata.port         = port_r;
                wdata.last_packets = '0;
                res_nxt.event_res  = mlt_pkg::EV_MOVED;
              end
              state_nxt = mlt_pkg::S_OUT;
            end else begin
              if (!valid_r[chk_idx_r] && !fr_found_r) begin
                fr_found_nxt = 1'b1;
                fr_nxt       = chk_idx_r;
              end
              if (chk_idx_r == LAST_IDX) begin
                state_nxt = mlt_pkg::S_OUT;
                if ((total_r >= cap_r) || !free_any) begin
                  res_nxt = '{mlt_pkg::STS_FULL, mlt_pkg::EV_NONE, 7'd0, 6'd0};
                end else begin
                  ctl.we                 = 1'b1;
                  ctl.waddr              = free_sel;
                  wdata.switch_id        = sw_r;
                  wdata.vlan             = vl_r;
                  wdata.mac              = mac_r;
                  wdata.port             = port_r;
                  wdata.last_seen        = now_r;
                  wdata.last_packets     = '0;
                  wdata.in_retry         = 1'b0;
                  wdata.retry_cnt        = '0;
                  wdata.next_retry       = '0;
                  valid_nxt[free_sel]    = 1'b1;
                  total_nxt              = total_r + 7'd1;
                  res_nxt = '{mlt_pkg::STS_OK, mlt_pkg::EV_ADDED, 7'd0, 6'(free_sel)};
                end
              end
            end
          end else begin
            if (flush_hit) begin
              valid_nxt[chk_idx_r] = 1'b0;
              if (total_r != 7'd0) begin
                total_nxt = total_r - 7'd1;
              end
            end
            rem_nxt = rem_new;
            if (chk_idx_r == LAST_IDX) begin
              res_nxt = '{mlt_pkg::STS_OK,
                          (rem_new != 7'd0) ? mlt_pkg::EV_REMOVED : mlt_pkg::EV_NONE,
                          rem_new, 6'd0};
              state_nxt = mlt_pkg::S_OUT;
            end
          end
        end
      end

      mlt_pkg::S_AGE_RD: begin
        ctl.raddr = AW'(slot_r);
        if (!valid_r[AW'(slot_r)]) begin
          res_nxt   = '{mlt_pkg::STS_OK, mlt_pkg::EV_NONE, 7'd0, slot_r};
          state_nxt = mlt_pkg::S_OUT;
        end else begin
          state_nxt = mlt_pkg::S_AGE_CALC;
        end
      end

      mlt_pkg::S_AGE_CALC: begin
        ctl.raddr    = AW'(slot_r);
        idle_nxt     = now_r - rd.last_seen;
        aging_ns_nxt = aging_r * NS62;
        retries_nxt  = (rd.retry_cnt == '1) ? rd.retry_cnt :
                       rd.retry_cnt + 32'd1;
        state_nxt    = mlt_pkg::S_AGE_EVAL;
      end

      mlt_pkg::S_AGE_EVAL: begin
        ctl.raddr = AW'(slot_r);
        ctl.waddr = AW'(slot_r);
        state_nxt = mlt_pkg::S_OUT;
        res_nxt   = '{mlt_pkg::STS_OK, mlt_pkg::EV_NONE, 7'd0, slot_r};
        if ((rd.next_retry != 64'd0) && (now_r < rd.next_retry)) begin
          res_nxt.event_res = mlt_pkg::EV_RETRY;
        end else if (!ok_r) begin
          ctl.we              = 1'b1;
          wdata.in_retry      = 1'b1;
          wdata.retry_cnt     = retries_r;
          wdata.next_retry    = now_r + mlt_pkg::backoff_ns(retries_r);
          res_nxt.status      = mlt_pkg::STS_QFAIL;
          if (idle_r >= aging_ns64 + mlt_pkg::GRACE_NS) begin
            valid_nxt[AW'(slot_r)] = 1'b0;
            if (total_r != 7'd0) begin
              total_nxt = total_r - 7'd1;
            end
            res_nxt.event_res     = mlt_pkg::EV_REMOVED;
            res_nxt.removed_count = 7'd1;
          end else begin
            res_nxt.event_res = mlt_pkg::EV_RETRY;
          end
        end else begin
          ctl.we              = 1'b1;
          wdata.in_retry      = 1'b0;
          wdata.retry_cnt     = '0;
          wdata.next_retry    = '0;
          if (pk_r != rd.last_packets) begin
            wdata.last_packets = pk_r;
            wdata.last_seen    = now_r;
            res_nxt.event_res  = mlt_pkg::EV_ACTIVITY;
          end else if (idle_r >= aging_ns64) begin
            valid_nxt[AW'(slot_r)] = 1'b0;
            if (total_r != 7'd0) begin
              total_nxt = total_r - 7'd1;
            end
            res_nxt.event_res     = mlt_pkg::EV_REMOVED;
            res_nxt.removed_count = 7'd1;
          end
        end
      end

      mlt_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = mlt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mlt_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_event_res     = out_res_r.event_res;
  assign out_removed_count = out_res_r.removed_count;
  assign out_entry_slot    = out_res_r.entry_slot;

`ifndef SYNTH
  a_total_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == 7'($countones(valid_r)))
    else $error("entry count differs from valid bits");

  a_total_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= 7'(mlt_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mlt_pkg::S_OUT && !out_valid_r) |=> (out_valid_r && state_r == mlt_pkg::S_IDLE))
    else $error("finished result not registered");

  a_table_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.we |-> (state_r == mlt_pkg::S_SCAN || state_r == mlt_pkg::S_AGE_EVAL))
    else $error("entry write outside a scan or age step");
`endif

endmodule
